### rtl/ccfr_pkg.sv
// ccfr_pkg: shared types and constants for the cobs crc frame receiver
// no dependencies
`default_nettype none
package ccfr_pkg;
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam int unsigned MinFrame = 6;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_MALFORMED = 3'd2,
    ST_SHORT     = 3'd3,
    ST_LENGTH    = 3'd4,
    ST_CRC       = 3'd5
  } status_e;

  typedef enum logic {
    ACT_FEED = 1'b0,
    ACT_READ = 1'b1
  } action_e;

  typedef enum logic {
    KIND_REPORT = 1'b0,
    KIND_READ   = 1'b1
  } kind_e;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] status;
    logic [7:0] frame_type;
    logic [7:0] frame_seq;
    logic [7:0] payload_length;
    logic [7:0] data_byte;
  } out_t;

  // queued work from front to back
  typedef struct packed {
    logic       is_read;
    logic       is_delim;
    logic       push;
    logic [7:0] byte_v;
    logic [7:0] read_index;
  } cmd_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction
endpackage
`default_nettype wire

### rtl/ccfr_front.sv
// ccfr_front: cobs group tracking and coded byte counting
// depends on ccfr_pkg
`default_nettype none
module ccfr_front #(
  parameter int unsigned CODED_DEPTH = 260
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire ccfr_pkg::in_t in_data_i,
  output logic               cmd_valid_o,
  input  wire logic          cmd_ready_i,
  output ccfr_pkg::cmd_t     cmd_o
);
  import ccfr_pkg::*;
  localparam int unsigned CW = $clog2(CODED_DEPTH + 1);

  logic [CW-1:0] coded_q, coded_d;
  logic          ovr_q, ovr_d;
  logic [7:0]    left_q, left_d;
  logic          full_q, full_d;
  logic          fire, pushit;

  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i;
  assign fire = in_valid_i && cmd_ready_i;

  always_comb begin
    coded_d = coded_q;
    ovr_d   = ovr_q;
    left_d  = left_q;
    full_d  = full_q;
    pushit  = 1'b0;
    cmd_o.is_read    = (in_data_i.action == ACT_READ);
    cmd_o.is_delim   = (in_data_i.action == ACT_FEED) && (in_data_i.rx_byte == 8'h00);
    cmd_o.byte_v     = in_data_i.rx_byte;
    cmd_o.read_index = in_data_i.read_index;
    if (in_data_i.action == ACT_FEED) begin
      if (in_data_i.rx_byte == 8'h00) begin
        // report ends frame; empty or coded-overflow frame and unfinished group flagged via byte_v
        coded_d = '0;
        ovr_d   = 1'b0;
        left_d  = '0;
        full_d  = 1'b0;
        cmd_o.byte_v = {6'd0, (left_q != 8'd0), (ovr_q || coded_q == '0)};
      end else if (coded_q < CW'(CODED_DEPTH)) begin
        coded_d = coded_q + 1'b1;
        if (!ovr_q) begin
          if (left_q == 8'd0) begin
            pushit = (coded_q != '0) && !full_q;
            cmd_o.byte_v = 8'h00;
            left_d = in_data_i.rx_byte - 8'd1;
            full_d = (in_data_i.rx_byte == 8'hFF);
          end else begin
            pushit = 1'b1;
            left_d = left_q - 8'd1;
          end
        end
      end else begin
        ovr_d = 1'b1;
      end
    end
    cmd_o.push = pushit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coded_q <= '0;
      ovr_q   <= 1'b0;
      left_q  <= '0;
      full_q  <= 1'b0;
    end else if (fire) begin
      coded_q <= coded_d;
      ovr_q   <= ovr_d;
      left_q  <= left_d;
      full_q  <= full_d;
    end
  end
endmodule
`default_nettype wire

### rtl/ccfr_queue.sv
// ccfr_queue: two-entry command queue between front and back
// depends on ccfr_pkg
`default_nettype none
module ccfr_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_valid_i,
  output logic                wr_ready_o,
  input  wire ccfr_pkg::cmd_t wr_data_i,
  output logic                rd_valid_o,
  input  wire logic           rd_ready_i,
  output ccfr_pkg::cmd_t      rd_data_o
);
  import ccfr_pkg::*;
  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule
`default_nettype wire

### rtl/ccfr_back.sv
// ccfr_back: payload store, crc delay line and frame report
// depends on ccfr_pkg
`default_nettype none
module ccfr_back #(
  parameter int unsigned RAW_DEPTH = 256
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  output logic                cmd_ready_o,
  input  wire ccfr_pkg::cmd_t cmd_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output ccfr_pkg::out_t      out_data_o
);
  import ccfr_pkg::*;
  localparam int unsigned AW = (RAW_DEPTH > 256) ? $clog2(RAW_DEPTH) : 8;
  localparam int unsigned SW = $clog2(RAW_DEPTH);
  localparam int unsigned DW = $clog2(RAW_DEPTH + 1);

  logic [7:0]    store_q [RAW_DEPTH];
  logic [DW-1:0] dcnt_q;
  logic          mal_q;
  logic [15:0]   crc_q, dly_q;
  logic [7:0]    hdr_q [4];
  logic          ov_q;
  out_t          out_q, out_d;
  logic [7:0]    rdat_q;
  logic          rsel_q, rok_q;
  logic          fire, wr_ok;
  logic [15:0]   len;
  logic [2:0]    st;
  logic [AW-1:0] ridx;

  // output register: issue when empty or being drained
  assign cmd_ready_o = !ov_q || out_ready_i;
  assign fire  = cmd_valid_i && cmd_ready_o;
  assign wr_ok = cmd_i.push && !mal_q && (dcnt_q < DW'(RAW_DEPTH));
  assign len   = {hdr_q[3], hdr_q[2]};
  assign ridx  = AW'(cmd_i.read_index);

  always_comb begin
    if (cmd_i.byte_v[0])                   st = ST_EMPTY;
    else if (mal_q || cmd_i.byte_v[1])     st = ST_MALFORMED;
    else if (dcnt_q < DW'(MinFrame))       st = ST_SHORT;
    else if (32'(dcnt_q) != 32'(len) + 32'(MinFrame)) st = ST_LENGTH;
    else if ({dly_q[7:0], dly_q[15:8]} != crc_q) st = ST_CRC;
    else                                   st = ST_OK;
  end

  always_comb begin
    out_d = '0;
    if (cmd_i.is_read) out_d.kind = KIND_READ;
    else begin
      out_d.kind   = KIND_REPORT;
      out_d.status = st;
      if (st == ST_OK || st == ST_LENGTH || st == ST_CRC) begin
        out_d.frame_type     = hdr_q[0];
        out_d.frame_seq      = hdr_q[1];
        out_d.payload_length = (len > 16'd255) ? 8'hFF : len[7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && wr_ok) store_q[dcnt_q[SW-1:0]] <= cmd_i.byte_v;
    if (fire && cmd_i.is_read) begin
      rdat_q <= store_q[ridx[SW-1:0]];
      rok_q  <= (32'(ridx) < 32'(RAW_DEPTH));
    end
    if (fire && wr_ok && dcnt_q < DW'(4)) hdr_q[dcnt_q[1:0]] <= cmd_i.byte_v;
    if (fire) begin
      out_q  <= out_d;
      rsel_q <= cmd_i.is_read;
    end
  end

  always_comb begin
    out_data_o = out_q;
    if (rsel_q) out_data_o.data_byte = rok_q ? rdat_q : 8'h00;
  end
  assign out_valid_o = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q   <= 1'b0;
      dcnt_q <= '0;
      mal_q  <= 1'b0;
      crc_q  <= CrcInit;
      dly_q  <= '0;
    end else begin
      if (fire) ov_q <= cmd_i.is_read || cmd_i.is_delim;
      else if (out_ready_i) ov_q <= 1'b0;
      if (fire && cmd_i.is_delim) begin
        dcnt_q <= '0;
        mal_q  <= 1'b0;
        crc_q  <= CrcInit;
        dly_q  <= '0;
      end else if (fire && cmd_i.push && !mal_q) begin
        if (wr_ok) begin
          if (dcnt_q >= DW'(2)) crc_q <= crc_byte(crc_q, dly_q[15:8]);
          dly_q  <= {dly_q[7:0], cmd_i.byte_v};
          dcnt_q <= dcnt_q + 1'b1;
        end else begin
          mal_q <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### rtl/cobs_crc_frame_receiver.sv
// cobs_crc_frame_receiver: top level, front classifier, queue and back end
// depends on ccfr_pkg, ccfr_front, ccfr_queue, ccfr_back
// throughput one transaction per cycle while the output is not stalled; a result passes
// through the queue and the output register; the crc update is one byte per cycle while bytes flow
// reset clears control state and frame counters; the payload store, header bytes and output register are not cleared
`default_nettype none
module cobs_crc_frame_receiver #(
  parameter int unsigned RAW_DEPTH   = 256,
  parameter int unsigned CODED_DEPTH = 260
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire ccfr_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output ccfr_pkg::out_t      out_data_o
);
  import ccfr_pkg::*;
  // front to queue
  logic fq_valid, fq_ready;
  cmd_t fq_cmd;
  // queue to back
  logic qb_valid, qb_ready;
  cmd_t qb_cmd;

  // front tracks cobs groups and the coded byte limit
  ccfr_front #(.CODED_DEPTH(CODED_DEPTH)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .cmd_valid_o(fq_valid), .cmd_ready_i(fq_ready), .cmd_o(fq_cmd)
  );

  // short queue decouples classification from store access
  ccfr_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(fq_valid), .wr_ready_o(fq_ready), .wr_data_i(fq_cmd),
    .rd_valid_o(qb_valid), .rd_ready_i(qb_ready), .rd_data_o(qb_cmd)
  );

  // back end writes decoded bytes, runs the crc, forms reports and answers reads
  ccfr_back #(.RAW_DEPTH(RAW_DEPTH)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(qb_valid), .cmd_ready_o(qb_ready), .cmd_i(qb_cmd),
    .out_valid_o, .out_ready_i, .out_data_o
  );
endmodule
`default_nettype wire

### rtl/ccfr_checker.sv
// ccfr_checker: port level checks for the frame receiver, with bind
// depends on ccfr_pkg
`default_nettype none
module ccfr_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_o,
  input wire ccfr_pkg::in_t  in_data_i,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire ccfr_pkg::out_t out_data_o
);
  import ccfr_pkg::*;
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= ST_CRC)
    else $error("status out of range");
  a_read_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_READ |-> out_data_o.status == ST_OK
      && out_data_o.frame_type == 8'd0 && out_data_o.payload_length == 8'd0)
    else $error("read answer carries report fields");
  a_report_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_REPORT |-> out_data_o.data_byte == 8'd0
      && (out_data_o.status == ST_OK || out_data_o.status == ST_LENGTH
      || out_data_o.status == ST_CRC || out_data_o.payload_length == 8'd0))
    else $error("report fields inconsistent");
endmodule

bind cobs_crc_frame_receiver ccfr_checker u_checker (.*);
`default_nettype wire
